// ----- design/kway_merge_min_select_top_macros.svh -----
// Assertion macros used by the merge selector controller.
`ifndef KWAY_MERGE_MIN_SELECT_TOP_MACROS_SVH
`define KWAY_MERGE_MIN_SELECT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KMMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KMMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/kmms_pkg.sv -----
package kmms_pkg;

  // Fixed field widths of the channels.
  localparam int STREAM_W = 4;
  localparam int CNT_W    = 5;
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } kmms_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic out_load;
  } kmms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic issue_last;
    logic out_free;
  } kmms_sts_t;

endpackage

// ----- design/kmms_if.sv -----
interface kmms_in_if import kmms_pkg::*; #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [STREAM_W-1:0]   stream;
  logic [VALUE_BITS-1:0] value;
  logic                  exhausted;

  modport source (output valid, output stream, output value, output exhausted, input ready);
  modport sink   (input valid, input stream, input value, input exhausted, output ready);
endinterface

interface kmms_out_if import kmms_pkg::*; #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] least_value;
  logic [STREAM_W-1:0]   min_stream;
  logic                  done_res;

  modport source (output valid, output least_value, output min_stream, output done_res,
                  input ready);
  modport sink   (input valid, input least_value, input min_stream, input done_res,
                  output ready);
endinterface

interface kmms_cfg_if import kmms_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/kmms_ram.sv -----
module kmms_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/kmms_ctrl.sv -----
`include "kway_merge_min_select_top_macros.svh"

module kmms_ctrl import kmms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  kmms_sts_t sts,
  output kmms_cmd_t cmd
);

  kmms_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.need_scan) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `KMMS_ASSERT_NEXT(a_scan_ends, clk, rst_n, (state_r == ST_SCAN) && sts.issue_last, state_r == ST_DRAIN, "scan did not stop after the last slot")
  `KMMS_ASSERT_NEXT(a_load_stays, clk, rst_n, cmd.accept && !sts.need_scan, state_r == ST_IDLE, "load transfer started a scan")
  `KMMS_ASSERT_NEXT(a_finish_out, clk, rst_n, (state_r == ST_FINISH) && sts.out_free, (state_r == ST_IDLE) && !cmd.scan_step, "result not handed over")

endmodule

// ----- design/kmms_dp.sv -----
module kmms_dp import kmms_pkg::*; #(
  parameter int MAX_STREAMS = 16,
  parameter int VALUE_BITS  = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kmms_cmd_t             cmd,
  output kmms_sts_t             sts,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_data,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_exhausted,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_least_value,
  output logic [STREAM_W-1:0]   out_min_stream,
  output logic                  out_done_res
);

  localparam int SLOT_W = $clog2(MAX_STREAMS);

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       loaded_r, loaded_nxt;
  logic [MAX_STREAMS-1:0] live_r, live_nxt;
  logic [SLOT_W-1:0]      last_r, last_nxt;
  logic [SLOT_W-1:0]      idx_r;
  logic [SLOT_W-1:0]      cmp_idx_r;
  logic                   cmp_v_r;
  logic                   found_r;
  logic [VALUE_BITS-1:0]  best_r;
  logic [SLOT_W-1:0]      best_idx_r;
  logic                   out_valid_r;
  logic [VALUE_BITS-1:0]  out_value_r;
  logic [STREAM_W-1:0]    out_stream_r;
  logic                   out_done_r;

  logic [CNT_W-1:0]       n_eff;
  logic [CNT_W-1:0]       loaded_inc;
  logic                   loading;
  logic [SLOT_W-1:0]      slot;
  logic [VALUE_BITS-1:0]  rd_data;
  logic                   hit;

  // A count of zero acts as one; a count above the slot total is clamped.
  always_comb begin
    if (count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(count_r) > MAX_STREAMS) begin
      n_eff = CNT_W'(MAX_STREAMS);
    end else begin
      n_eff = count_r;
    end
  end

  assign loading    = (loaded_r < n_eff);
  assign loaded_inc = loaded_r + CNT_W'(1);
  assign slot       = loading ? SLOT_W'(loaded_r) : last_r;

  assign sts.need_scan  = !(loading && (loaded_inc < n_eff));
  assign sts.issue_last = (CNT_W'(idx_r) == (n_eff - CNT_W'(1)));
  assign sts.out_free   = !out_valid_r || out_ready;

  kmms_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_STREAMS)
  ) u_heads (
    .clk   (clk),
    .we    (cmd.accept && !in_exhausted),
    .waddr (slot),
    .wdata (in_value),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  assign hit = cmp_v_r && live_r[cmp_idx_r] && (!found_r || (rd_data <= best_r));

  always_comb begin
    live_nxt   = live_r;
    loaded_nxt = loaded_r;
    last_nxt   = last_r;
    if (cfg_we) begin
      live_nxt   = '0;
      loaded_nxt = '0;
      last_nxt   = '0;
    end else if (cmd.accept) begin
      live_nxt[slot] = !in_exhausted;
      if (loading) begin
        loaded_nxt = loaded_inc;
      end
    end else if (cmd.out_load) begin
      if (found_r) begin
        last_nxt = best_idx_r;
      end else begin
        live_nxt   = '0;
        loaded_nxt = '0;
        last_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNT_RESET;
      loaded_r    <= '0;
      live_r      <= '0;
      last_r      <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_data;
      end
      loaded_r <= loaded_nxt;
      live_r   <= live_nxt;
      last_r   <= last_nxt;
      cmp_v_r  <= cmd.scan_step;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.scan_step) begin
        idx_r <= idx_r + SLOT_W'(1);
      end
      if (hit) begin
        found_r <= 1'b1;
      end
    end
    cmp_idx_r <= idx_r;
    if (hit) begin
      best_r     <= rd_data;
      best_idx_r <= cmp_idx_r;
    end
    if (cmd.out_load) begin
      out_done_r   <= !found_r;
      out_value_r  <= found_r ? best_r : '0;
      out_stream_r <= found_r ? STREAM_W'(best_idx_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_least_value = out_value_r;
  assign out_min_stream  = out_stream_r;
  assign out_done_res    = out_done_r;

endmodule

// ----- design/kway_merge_min_select_top.sv -----
// K-way merge selector. The in_ch channel carries one transfer per stream
// head: during the load phase one transfer for each of slots 0 to
// stream_count minus one, in that order, and after that one transfer per
// result, which refills the slot last reported on out_ch. The stream field
// is informational; the slot is chosen internally. The cfg_ch channel writes
// stream_count and restarts the load phase; it is always ready and must only
// be used while the block is idle.
// A load transfer that does not complete the load gives no result and the
// block stays idle. Any other transfer starts a scan of the stored heads
// through the single read port of the head RAM, one slot per cycle, over
// the effective stream count of slots; the block then passes a drain state
// and moves the result into the output register, and takes no new transfer
// before that.
// The result sits in an output register; when out_ch is stalled the block
// finishes its scan and then holds until the register is free.
// Reset clears the live flags, the load count and the last reported stream
// and sets stream_count to sixteen. The head RAM is not cleared, since a
// head is only ever used after it has been written.
module kway_merge_min_select_top import kmms_pkg::*; #(
  parameter int MAX_STREAMS = 16,
  parameter int VALUE_BITS  = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  kmms_in_if.sink     in_ch,
  kmms_out_if.source  out_ch,
  kmms_cfg_if.sink    cfg_ch
);

  kmms_cmd_t cmd;
  kmms_sts_t sts;

  // Configuration writes are taken in any cycle.
  assign cfg_ch.ready = 1'b1;

  // The sequencer decides when a transfer is taken, when the scan runs and
  // when the result is moved into the output register.
  kmms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the heads, the live flags, the running minimum and
  // the output register.
  kmms_dp #(
    .MAX_STREAMS (MAX_STREAMS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_ch.valid),
    .cfg_data        (cfg_ch.data),
    .in_value        (in_ch.value),
    .in_exhausted    (in_ch.exhausted),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_least_value (out_ch.least_value),
    .out_min_stream  (out_ch.min_stream),
    .out_done_res    (out_ch.done_res)
  );

endmodule
